### rtl/tsfm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tsfm_pkg: shared constants and types for the touch sample filter and mapper
// Widths, filter constants, register indices and internal event codes.
// ----------------------------------------------------------------------------
package tsfm_pkg;

  localparam int SAMPLE_W    = 12;
  localparam int POS_W       = 16;
  localparam int GAIN_W      = 16;
  localparam int FRAC_W      = 14;   // Q2.14 gain
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 3;

  localparam int SPG         = 5;    // samples per group
  localparam int AGREE_RANGE = 50;
  localparam int NUM_GROUPS  = 4;    // X, Y of two passes
  localparam int GRP_W       = 2;
  localparam int CNT_W       = $clog2(SPG);
  localparam int SUM_W       = SAMPLE_W + $clog2(SPG);

  // trimmed mean divisor, done as a multiply by a rounded-up reciprocal
  localparam int TRIM_DIV    = SPG - 2;
  localparam int RECIP_SH    = SUM_W + 4;
  localparam int RECIP_W     = RECIP_SH + 1;
  localparam int RECIP       = ((1 << RECIP_SH) + TRIM_DIV - 1) / TRIM_DIV;

  localparam logic [POS_W-1:0] NO_TOUCH = {POS_W{1'b1}};

  // configuration register indices
  localparam logic [CFG_IDX_W-1:0] REG_RAW_MODE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_X_CENTER      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_Y_CENTER      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_X_GAIN        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_Y_GAIN        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd6;

  // event moving down the pipeline
  typedef enum logic [0:0] {
    EV_PENUP = 1'b0,
    EV_GROUP = 1'b1
  } ev_kind_e;

endpackage
`default_nettype wire

### rtl/tsfm_map_axis.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tsfm_map_axis: ADC to screen pixel mapping for one axis
// Registered signed product (value - centre) * gain, then offset by half the
// screen size, truncated toward zero and clamped to the screen.
// ----------------------------------------------------------------------------
module tsfm_map_axis (
  input  wire logic                                 clk_i,
  input  wire logic                                 load_i,
  input  wire logic        [tsfm_pkg::SAMPLE_W-1:0] val_i,
  input  wire logic        [tsfm_pkg::SAMPLE_W-1:0] centre_i,
  input  wire logic signed [tsfm_pkg::GAIN_W-1:0]   gain_i,
  input  wire logic        [tsfm_pkg::SAMPLE_W-1:0] size_i,
  output logic             [tsfm_pkg::POS_W-1:0]    pix_o
);

  localparam int DIFF_W = tsfm_pkg::SAMPLE_W + 1;
  localparam int PROD_W = DIFF_W + tsfm_pkg::GAIN_W;
  localparam int P_W    = PROD_W + 1;
  localparam int OFS_W  = tsfm_pkg::SAMPLE_W - 1 + tsfm_pkg::FRAC_W;

  logic signed [DIFF_W-1:0] diff;
  logic signed [PROD_W-1:0] prod_d, prod_q;
  logic signed [P_W-1:0]    p_sum, p_adj;
  logic [tsfm_pkg::POS_W-1:0] unclamped, size_ext;

  assign diff   = $signed({1'b0, val_i}) - $signed({1'b0, centre_i});
  assign prod_d = diff * gain_i;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      prod_q <= prod_d;
    end
  end

  assign p_sum = $signed({prod_q[PROD_W-1], prod_q})
               + $signed({{(P_W-OFS_W){1'b0}}, size_i[tsfm_pkg::SAMPLE_W-1:1],
                          {tsfm_pkg::FRAC_W{1'b0}}});
  // negative sums round toward zero
  assign p_adj = p_sum[P_W-1] ? p_sum + $signed(P_W'((1 << tsfm_pkg::FRAC_W) - 1)) : p_sum;

  assign unclamped = p_adj[tsfm_pkg::FRAC_W +: tsfm_pkg::POS_W];
  assign size_ext  = {{(tsfm_pkg::POS_W-tsfm_pkg::SAMPLE_W){1'b0}}, size_i};
  assign pix_o     = (unclamped >= size_ext) ? size_ext - 16'd1 : unclamped;

endmodule
`default_nettype wire

### rtl/touch_sample_filter_and_mapper.sv
`default_nettype none
// Results: the last sample of a scan, or a pen-up event, passes through v1_q,
//   v2_q, v3_q, v4_q and m_v_q to a valid result; other samples give no result.
// Throughput: one sample per cycle; the five-stage event pipeline stalls only
//   when the output register is full and not taken.
// Reset: counters, group accumulators, press latch and position state take their
//   idle values at once; no clearing pass.
// ----------------------------------------------------------------------------
// touch_sample_filter_and_mapper: trimmed-mean touch filter with screen mapping
// Groups ADC samples into trimmed means, checks two passes for agreement and
// maps the averaged point to screen pixels, with a first-press latch.
// ----------------------------------------------------------------------------
module touch_sample_filter_and_mapper (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration
  input  wire logic                             cfg_we_i,
  input  wire logic [tsfm_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [tsfm_pkg::CFG_W-1:0]       cfg_wdata_i,
  // sample stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // [11:0] sample, [15:12] zero
  input  wire logic [0:0]  s_axis_tuser,   // [0] pen_down
  // result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [63:0]      m_axis_tdata,   // pos_x, pos_y, first_x, first_y
  output logic [1:0]       m_axis_tuser    // [0] pressed, [1] reads_agreed
);

  localparam int SW = tsfm_pkg::SAMPLE_W;
  localparam int PW = tsfm_pkg::POS_W;

  // configuration registers
  logic                              raw_mode_q;
  logic [SW-1:0]                     x_center_q, y_center_q;
  logic signed [tsfm_pkg::GAIN_W-1:0] x_gain_q, y_gain_q;
  logic [SW-1:0]                     scr_w_q, scr_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_mode_q <= 1'b0;
      x_center_q <= 12'd2048;
      y_center_q <= 12'd2048;
      x_gain_q   <= 16'sd1200;
      y_gain_q   <= 16'sd1200;
      scr_w_q    <= 12'd240;
      scr_h_q    <= 12'd320;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tsfm_pkg::REG_RAW_MODE:      raw_mode_q <= cfg_wdata_i[0];
        tsfm_pkg::REG_X_CENTER:      x_center_q <= cfg_wdata_i[SW-1:0];
        tsfm_pkg::REG_Y_CENTER:      y_center_q <= cfg_wdata_i[SW-1:0];
        tsfm_pkg::REG_X_GAIN:        x_gain_q   <= $signed(cfg_wdata_i);
        tsfm_pkg::REG_Y_GAIN:        y_gain_q   <= $signed(cfg_wdata_i);
        tsfm_pkg::REG_SCREEN_WIDTH:  scr_w_q    <= cfg_wdata_i[SW-1:0];
        tsfm_pkg::REG_SCREEN_HEIGHT: scr_h_q    <= cfg_wdata_i[SW-1:0];
        default: begin
        end
      endcase
    end
  end

  // pipeline handshake
  logic v1_q, v2_q, v3_q, v4_q, m_v_q;
  logic rdy1, rdy2, rdy3, rdy4, rdy_o;
  logic fwd2, commit;

  // ---------------- stage 0: group accumulation ----------------
  logic                         in_acc, pen;
  logic [SW-1:0]                smp;
  logic [tsfm_pkg::CNT_W-1:0]   smp_cnt_q;
  logic [tsfm_pkg::GRP_W-1:0]   grp_cnt_q;
  logic [tsfm_pkg::SUM_W-1:0]   sum_q, sum_nx;
  logic [SW-1:0]                min_q, max_q, min_nx, max_nx;
  logic                         grp_done;

  assign in_acc   = s_axis_tvalid & s_axis_tready;
  assign pen      = s_axis_tuser[0];
  assign smp      = s_axis_tdata[SW-1:0];
  assign sum_nx   = sum_q + tsfm_pkg::SUM_W'(smp);
  assign min_nx   = (smp < min_q) ? smp : min_q;
  assign max_nx   = (smp > max_q) ? smp : max_q;
  assign grp_done = pen && (smp_cnt_q == tsfm_pkg::CNT_W'(tsfm_pkg::SPG - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smp_cnt_q <= '0;
      grp_cnt_q <= '0;
      sum_q     <= '0;
      min_q     <= '1;
      max_q     <= '0;
    end else if (in_acc) begin
      if (!pen || grp_done) begin
        smp_cnt_q <= '0;
        sum_q     <= '0;
        min_q     <= '1;
        max_q     <= '0;
        if (!pen || grp_cnt_q == tsfm_pkg::GRP_W'(tsfm_pkg::NUM_GROUPS - 1)) begin
          grp_cnt_q <= '0;
        end else begin
          grp_cnt_q <= grp_cnt_q + 2'd1;
        end
      end else begin
        smp_cnt_q <= smp_cnt_q + tsfm_pkg::CNT_W'(1);
        sum_q     <= sum_nx;
        min_q     <= min_nx;
        max_q     <= max_nx;
      end
    end
  end

  // ---------------- stage 1: group totals ----------------
  tsfm_pkg::ev_kind_e           r1_kind;
  logic [tsfm_pkg::GRP_W-1:0]   r1_grp;
  logic [tsfm_pkg::SUM_W-1:0]   r1_sum;
  logic [SW-1:0]                r1_min, r1_max;

  assign rdy1          = !v1_q || rdy2;
  assign s_axis_tready = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (rdy1) begin
      v1_q <= in_acc && (!pen || grp_done);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && (!pen || grp_done)) begin
      r1_kind <= pen ? tsfm_pkg::EV_GROUP : tsfm_pkg::EV_PENUP;
      r1_grp  <= grp_cnt_q;
      r1_sum  <= sum_nx;
      r1_min  <= min_nx;
      r1_max  <= max_nx;
    end
  end

  // trimmed mean: (sum - min - max) / (SPG - 2) via reciprocal multiply
  localparam logic [tsfm_pkg::RECIP_W-1:0] RecipC = tsfm_pkg::RECIP_W'(tsfm_pkg::RECIP);
  logic [tsfm_pkg::SUM_W-1:0]                  trim;
  logic [tsfm_pkg::SUM_W+tsfm_pkg::RECIP_W-1:0] quot_prod;
  logic [SW-1:0]                               mean;

  assign trim      = r1_sum - tsfm_pkg::SUM_W'(r1_min) - tsfm_pkg::SUM_W'(r1_max);
  assign quot_prod = trim * RecipC;
  assign mean      = quot_prod[tsfm_pkg::RECIP_SH +: SW];

  // ---------------- stage 2: pass compare ----------------
  tsfm_pkg::ev_kind_e           r2_kind;
  logic [tsfm_pkg::GRP_W-1:0]   r2_grp;
  logic [SW-1:0]                r2_mean;
  logic [SW-1:0]                pass_q [3];
  logic [SW-1:0]                dx, dy;
  logic [SW:0]                  sx, sy;
  logic                         agree;

  assign fwd2 = (r2_kind == tsfm_pkg::EV_PENUP)
             || (r2_grp == tsfm_pkg::GRP_W'(tsfm_pkg::NUM_GROUPS - 1));
  assign rdy2 = !v2_q || !fwd2 || rdy3;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (rdy2) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      r2_kind <= r1_kind;
      r2_grp  <= r1_grp;
      r2_mean <= mean;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pass_q[0] <= '0;
      pass_q[1] <= '0;
      pass_q[2] <= '0;
    end else if (v2_q && !fwd2) begin
      pass_q[r2_grp] <= r2_mean;
    end
  end

  assign dx    = (pass_q[0] > pass_q[2]) ? pass_q[0] - pass_q[2] : pass_q[2] - pass_q[0];
  assign dy    = (pass_q[1] > r2_mean)   ? pass_q[1] - r2_mean   : r2_mean - pass_q[1];
  assign agree = (dx < SW'(tsfm_pkg::AGREE_RANGE)) && (dy < SW'(tsfm_pkg::AGREE_RANGE));
  assign sx    = {1'b0, pass_q[0]} + {1'b0, pass_q[2]};
  assign sy    = {1'b0, pass_q[1]} + {1'b0, r2_mean};

  // ---------------- stage 3: mapping product ----------------
  tsfm_pkg::ev_kind_e r3_kind;
  logic               r3_agreed;
  logic [SW-1:0]      r3_ax, r3_ay;

  assign rdy3 = !v3_q || rdy4;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (rdy3) begin
      v3_q <= v2_q && fwd2;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q && fwd2) begin
      r3_kind   <= r2_kind;
      r3_agreed <= agree;
      r3_ax     <= sx[SW:1];
      r3_ay     <= sy[SW:1];
    end
  end

  // ---------------- stage 4: clamp and state update ----------------
  tsfm_pkg::ev_kind_e r4_kind;
  logic               r4_agreed;
  logic [SW-1:0]      r4_ax, r4_ay;
  logic               ld4;
  logic [PW-1:0]      pix_x, pix_y;

  assign rdy4 = !v4_q || rdy_o;
  assign ld4  = rdy4 && v3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (rdy4) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld4) begin
      r4_kind   <= r3_kind;
      r4_agreed <= r3_agreed;
      r4_ax     <= r3_ax;
      r4_ay     <= r3_ay;
    end
  end

  tsfm_map_axis u_map_x (
    .clk_i    (clk_i),
    .load_i   (ld4),
    .val_i    (r3_ax),
    .centre_i (x_center_q),
    .gain_i   (x_gain_q),
    .size_i   (scr_w_q),
    .pix_o    (pix_x)
  );

  tsfm_map_axis u_map_y (
    .clk_i    (clk_i),
    .load_i   (ld4),
    .val_i    (r3_ay),
    .centre_i (y_center_q),
    .gain_i   (y_gain_q),
    .size_i   (scr_h_q),
    .pix_o    (pix_y)
  );

  logic          latch_q, latch_d;
  logic [PW-1:0] last_x_q, last_y_q, last_x_d, last_y_d;
  logic [PW-1:0] first_x_q, first_y_q, first_x_d, first_y_d;
  logic [PW-1:0] new_x, new_y;

  assign rdy_o  = !m_v_q || m_axis_tready;
  assign commit = v4_q && rdy_o;
  assign new_x  = raw_mode_q ? {{(PW-SW){1'b0}}, r4_ax} : pix_x;
  assign new_y  = raw_mode_q ? {{(PW-SW){1'b0}}, r4_ay} : pix_y;

  always_comb begin
    latch_d   = latch_q;
    last_x_d  = last_x_q;
    last_y_d  = last_y_q;
    first_x_d = first_x_q;
    first_y_d = first_y_q;
    unique case (r4_kind)
      tsfm_pkg::EV_PENUP: begin
        if (latch_q) begin
          latch_d = 1'b0;
        end else begin
          first_x_d = '0;
          first_y_d = '0;
          last_x_d  = tsfm_pkg::NO_TOUCH;
          last_y_d  = tsfm_pkg::NO_TOUCH;
        end
      end
      tsfm_pkg::EV_GROUP: begin
        if (r4_agreed) begin
          last_x_d = new_x;
          last_y_d = new_y;
        end
        // press starts: first point is the position after this scan
        if (!latch_q) begin
          latch_d   = 1'b1;
          first_x_d = last_x_d;
          first_y_d = last_y_d;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      latch_q   <= 1'b0;
      last_x_q  <= tsfm_pkg::NO_TOUCH;
      last_y_q  <= tsfm_pkg::NO_TOUCH;
      first_x_q <= '0;
      first_y_q <= '0;
    end else if (commit) begin
      latch_q   <= latch_d;
      last_x_q  <= last_x_d;
      last_y_q  <= last_y_d;
      first_x_q <= first_x_d;
      first_y_q <= first_y_d;
    end
  end

  // ---------------- output register ----------------
  logic [63:0] out_data_q;
  logic [1:0]  out_user_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_v_q <= 1'b0;
    end else if (rdy_o) begin
      m_v_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      out_data_q <= {first_y_d, first_x_d, last_y_d, last_x_d};
      out_user_q <= {(r4_kind == tsfm_pkg::EV_GROUP) && r4_agreed, latch_d};
    end
  end

  assign m_axis_tvalid = m_v_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

`ifndef SYNTHESIS
  a_agreed_pressed : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tuser[0])
    else $error("agreed scan reported without press latch");

  a_penup_restart : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !s_axis_tuser[0] |=> (smp_cnt_q == '0) && (grp_cnt_q == '0))
    else $error("pen-up did not restart the scan");

  a_scan_latches : assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit && (r4_kind == tsfm_pkg::EV_GROUP) |=> latch_q)
    else $error("completed scan left press latch clear");

  a_cnt_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, smp_cnt_q} < (tsfm_pkg::CNT_W + 1)'(tsfm_pkg::SPG))
    else $error("sample counter out of range");
`endif

endmodule
`default_nettype wire

### dv/touch_sample_filter_and_mapper_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_sample_filter_and_mapper_tb: self-checking bench for the touch filter
// Drives pen-down/sample transfers in bursts, mostly complete scans with
// jitter, outliers and near-threshold pass offsets, plus pen-up events, cut
// scans and loose samples, under several register settings. A scoreboard
// class predicts every result and checks the result stream field by field.
// ----------------------------------------------------------------------------
module touch_sample_filter_and_mapper_tb;
  import tsfm_pkg::*;

  localparam int ONE_Q          = 1 << FRAC_W;
  localparam int RAND_PER_PHASE = 232;
  localparam int NUM_PHASES     = 8;
  localparam int DRAIN_CYCLES   = 8;
  localparam int STALL_LIMIT    = 4000;
  localparam int MAX_REPORTS    = 20;

  typedef struct packed {
    bit [15:0] pos_x;
    bit [15:0] pos_y;
    bit [15:0] first_x;
    bit [15:0] first_y;
    bit        pressed;
    bit        agreed;
  } scan_result_t;

  class scan_scoreboard;
    // register copies
    bit               raw_out;
    bit [11:0]        ctr_x, ctr_y;
    bit signed [15:0] gain_x, gain_y;
    bit [11:0]        width, height;
    // filter state
    int unsigned idx_in_scan, acc_sum, acc_min, acc_max;
    int unsigned means [3];
    bit [15:0]   cur_x, cur_y, start_x, start_y;
    bit          latched;
    scan_result_t expected_q [$];
    int unsigned errors, n_checked, n_agreed, n_refused, n_penup;

    function new();
      raw_out = 1'b0;
      ctr_x = 12'd2048;
      ctr_y = 12'd2048;
      gain_x = 16'sd1200;
      gain_y = 16'sd1200;
      width = 12'd240;
      height = 12'd320;
      idx_in_scan = 0;
      clear_group();
      means = '{0, 0, 0};
      cur_x = 16'hFFFF;
      cur_y = 16'hFFFF;
      start_x = '0;
      start_y = '0;
      latched = 1'b0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_RAW_MODE:      raw_out = val[0];
        REG_X_CENTER:      ctr_x = val[11:0];
        REG_Y_CENTER:      ctr_y = val[11:0];
        REG_X_GAIN:        gain_x = val;
        REG_Y_GAIN:        gain_y = val;
        REG_SCREEN_WIDTH:  width = val[11:0];
        REG_SCREEN_HEIGHT: height = val[11:0];
        default: ;
      endcase
    endfunction

    function void clear_group();
      acc_sum = 0;
      acc_min = 4095;
      acc_max = 0;
    endfunction

    function bit near(int unsigned a, int unsigned b);
      return ((a > b) ? a - b : b - a) < AGREE_RANGE;
    endfunction

    // offset from centre, scaled by Q2.14 gain, truncated toward zero;
    // anything outside the screen (negative too) clamps to size-1
    function bit [15:0] to_pixel(int unsigned val, int unsigned ctr,
                                 bit signed [15:0] gain, int unsigned size);
      int        d, p, q;
      bit [15:0] u;
      d = int'(val) - int'(ctr);
      p = d * int'(gain) + int'(size / 2) * ONE_Q;
      q = p / ONE_Q;
      u = q[15:0];
      if (u >= size) u = 16'(size - 1);
      return u;
    endfunction

    function void push_result(bit agreed);
      scan_result_t r;
      r.pos_x = cur_x;
      r.pos_y = cur_y;
      r.first_x = start_x;
      r.first_y = start_y;
      r.pressed = latched;
      r.agreed = agreed;
      expected_q.push_back(r);
    endfunction

    function void note_sample(bit pen, bit [11:0] smp);
      int unsigned mean, grp, ax, ay;
      bit          agreed;
      if (!pen) begin
        idx_in_scan = 0;
        clear_group();
        if (latched) begin
          latched = 1'b0;
        end else begin
          start_x = '0;
          start_y = '0;
          cur_x = 16'hFFFF;
          cur_y = 16'hFFFF;
        end
        n_penup++;
        push_result(1'b0);
        return;
      end
      acc_sum += smp;
      if (smp < acc_min) acc_min = smp;
      if (smp > acc_max) acc_max = smp;
      idx_in_scan++;
      if (idx_in_scan % SPG != 0) return;
      mean = (acc_sum - acc_min - acc_max) / (SPG - 2);
      clear_group();
      grp = idx_in_scan / SPG - 1;
      if (grp < 3) begin
        means[grp] = mean;
        return;
      end
      idx_in_scan = 0;
      agreed = near(means[0], means[2]) && near(means[1], mean);
      if (agreed) begin
        ax = (means[0] + means[2]) / 2;
        ay = (means[1] + mean) / 2;
        if (raw_out) begin
          cur_x = 16'(ax);
          cur_y = 16'(ay);
        end else begin
          cur_x = to_pixel(ax, ctr_x, gain_x, width);
          cur_y = to_pixel(ay, ctr_y, gain_y, height);
        end
        n_agreed++;
      end else begin
        n_refused++;
      end
      if (!latched) begin
        latched = 1'b1;
        start_x = cur_x;
        start_y = cur_y;
      end
      push_result(agreed);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MAX_REPORTS) $display("ERROR: %s", msg);
    endtask

    task check_result(logic [63:0] data, logic [1:0] user);
      scan_result_t e;
      if (expected_q.size() == 0) begin
        report($sformatf("result %h/%b with nothing pending", data, user));
        return;
      end
      e = expected_q.pop_front();
      n_checked++;
      if (data[15:0] !== e.pos_x)
        report($sformatf("pos_x got %0d exp %0d", data[15:0], e.pos_x));
      if (data[31:16] !== e.pos_y)
        report($sformatf("pos_y got %0d exp %0d", data[31:16], e.pos_y));
      if (data[47:32] !== e.first_x)
        report($sformatf("first_x got %0d exp %0d", data[47:32], e.first_x));
      if (data[63:48] !== e.first_y)
        report($sformatf("first_y got %0d exp %0d", data[63:48], e.first_y));
      if (user[0] !== e.pressed)
        report($sformatf("pressed got %b exp %b", user[0], e.pressed));
      if (user[1] !== e.agreed)
        report($sformatf("reads_agreed got %b exp %b", user[1], e.agreed));
    endtask
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0]     cfg_wdata_i = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [15:0]          s_axis_tdata = '0;   // [11:0] sample, [15:12] zero
  logic [0:0]           s_axis_tuser = '0;   // [0] pen_down
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [63:0]          m_axis_tdata;        // pos_x, pos_y, first_x, first_y
  logic [1:0]           m_axis_tuser;        // [0] pressed, [1] reads_agreed

  scan_scoreboard sb = new();
  int unsigned    items_sent = 0;
  int unsigned    burst_left = 0;
  bit             gaps_on = 1'b1;
  int unsigned    idle_cycles = 0;
  int unsigned    rx_cycle = 0;
  int unsigned    stall_left = 0;

  touch_sample_filter_and_mapper i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // receiver: ready pattern changes character with bits [9:8] of the cycle count
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser);
    rx_cycle <= rx_cycle + 1;
    case (rx_cycle[9:8])
      2'd0: m_axis_tready <= 1'b1;
      2'd1: m_axis_tready <= ($urandom_range(0, 3) != 0);
      2'd2: begin
        if (stall_left > 0) begin
          m_axis_tready <= 1'b0;
          stall_left <= stall_left - 1;
        end else begin
          m_axis_tready <= 1'b1;
          if ($urandom_range(0, 5) == 0) stall_left <= $urandom_range(1, 12);
        end
      end
      default: m_axis_tready <= rx_cycle[0];
    endcase
  end

  // watchdog: too long without any transfer on either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0 || !gaps_on) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
  endtask

  task automatic send_item(input bit pen, input bit [11:0] smp);
    pace();
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {4'b0, smp};
    s_axis_tuser <= pen;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_sample(pen, smp);
    items_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    sb.write_reg(idx, val);
  endtask

  // hold off the sender until every pending result is out and the pipe is empty
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic apply_config(input int phase);
    bit        raw;
    bit [11:0] xc, yc, w, h;
    bit [15:0] xg, yg;
    raw = ($urandom_range(0, 3) == 0);
    xc = 12'($urandom);
    yc = 12'($urandom);
    xg = 16'($urandom);
    yg = 16'($urandom);
    w = 12'($urandom_range(1, 4095));
    h = 12'($urandom_range(1, 4095));
    case (phase)
      1: raw = 1'b1;
      2: begin
        raw = 1'b0; xc = '0; yc = '0; xg = 16'h7FFF; yg = 16'h7FFF;
        w = 12'd4095; h = 12'd4095;
      end
      3: begin
        raw = 1'b0; xc = 12'd4095; yc = 12'd4095; xg = 16'h8000; yg = 16'h8000;
        w = 12'd1; h = 12'd1;
      end
      4: begin
        // zero screen size: clamp gives all ones
        raw = 1'b0; w = '0; h = '0;
      end
      5: begin
        raw = 1'b1; xc = 12'd4095; yc = '0; xg = 16'h8000; yg = 16'h7FFF;
      end
      6: begin
        raw = 1'b0; xg = 16'($urandom_range(0, 4000)); yg = 16'(-$urandom_range(0, 4000));
        w = 12'($urandom_range(100, 800)); h = 12'($urandom_range(100, 800));
      end
      default: ;
    endcase
    write_reg(REG_RAW_MODE, {15'b0, raw});
    write_reg(REG_X_CENTER, 16'(xc));
    write_reg(REG_Y_CENTER, 16'(yc));
    write_reg(REG_X_GAIN, xg);
    write_reg(REG_Y_GAIN, yg);
    write_reg(REG_SCREEN_WIDTH, 16'(w));
    write_reg(REG_SCREEN_HEIGHT, 16'(h));
    cfg_we_i <= 1'b0;
  endtask

  function automatic int pick_base();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return $urandom_range(0, 60);
    if (r == 1) return $urandom_range(4035, 4095);
    return $urandom_range(0, 4095);
  endfunction

  // one scan: X, Y of pass one, then X, Y of pass two offset by dx/dy;
  // a pen-up replaces the sample at cut_at when that lies inside the scan
  task automatic send_scan(input int xb, input int yb, input int dx, input int dy,
                           input int spread, input int cut_at);
    int grp, base, v;
    for (int n = 0; n < 4 * SPG; n++) begin
      if (n == cut_at) begin
        send_item(1'b0, 12'($urandom));
        return;
      end
      grp = n / SPG;
      base = grp[0] ? yb : xb;
      if (grp >= 2) base += grp[0] ? dy : dx;
      v = base + int'($urandom_range(0, 2 * spread)) - spread;
      if ($urandom_range(0, 9) == 0) v = $urandom_range(0, 4095);
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
      send_item(1'b1, 12'(v));
    end
  endtask

  task automatic random_chunk(input int unsigned count);
    int unsigned stop;
    int          kind, dx, dy, cut;
    stop = items_sent + count;
    while (items_sent < stop) begin
      kind = $urandom_range(0, 19);
      if (kind < 15) begin
        if ($urandom_range(0, 3) != 0) begin
          dx = int'($urandom_range(0, 100)) - 50;
          dy = int'($urandom_range(0, 100)) - 50;
        end else begin
          dx = int'($urandom_range(0, 600)) - 300;
          dy = int'($urandom_range(0, 600)) - 300;
        end
        cut = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4 * SPG - 1) : 4 * SPG;
        send_scan(pick_base(), pick_base(), dx, dy, $urandom_range(0, 30), cut);
      end else if (kind < 18) begin
        repeat ($urandom_range(1, 3)) send_item(1'b0, 12'($urandom));
      end else begin
        // loose samples that leave the scan out of step
        repeat ($urandom_range(1, 24)) send_item(1'b1, 12'($urandom));
        if ($urandom_range(0, 1) == 0) send_item(1'b0, 12'($urandom));
      end
    end
  endtask

  initial begin
    int v;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: pen-up while idle, a scan of extreme samples, pen-up while
    // latched, pen-up while idle again, then a scan cut short by pen-up
    send_item(1'b0, 12'hFFF);
    for (int n = 0; n < 4 * SPG; n++) begin
      if ((n / SPG) % 2 == 0)
        v = (n % SPG == 1) ? 0 : 4095;
      else
        v = (n % SPG == 1) ? 4095 : 0;
      send_item(1'b1, 12'(v));
    end
    send_item(1'b0, 12'h000);
    send_item(1'b0, 12'hA5A);
    send_item(1'b1, 12'h000);
    send_item(1'b1, 12'hFFF);
    send_item(1'b0, 12'h5A5);

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      if (phase != 0) begin
        wait_idle();
        apply_config(phase);
      end
      gaps_on = (phase % 3 != 2);
      random_chunk(RAND_PER_PHASE);
    end
    wait_idle();

    $display("Sent %0d samples under %0d register settings; checked %0d results",
             items_sent, NUM_PHASES, sb.n_checked);
    $display("  %0d agreed scans, %0d refused scans, %0d pen-up events, %0d mismatches",
             sb.n_agreed, sb.n_refused, sb.n_penup, sb.errors);
    if (sb.errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
